/* rtl/aes_pkg.sv */
`default_nettype none

package aes_pkg;

    typedef logic [127:0] block_t;

    localparam int NumRounds = 10;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [0:0] CfgKeyHigh = 1'b0;
    localparam logic [0:0] CfgKeyLow  = 1'b1;

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        gf_double = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] get_byte(input block_t blk, input int idx);
        get_byte = blk[127 - 8 * idx -: 8];
    endfunction

endpackage

`default_nettype wire

/* rtl/aes_round_cell.sv */
`default_nettype none

module aes_round_cell #(
    parameter logic [7:0] Rcon = 8'h01,
    parameter bit         LastRound = 1'b0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            valid_in,
    input  wire aes_pkg::block_t state_in,
    input  wire aes_pkg::block_t key_in,
    output logic                 valid_out,
    output aes_pkg::block_t      state_out,
    output aes_pkg::block_t      key_out
);
    import aes_pkg::*;

    logic   valid_reg;
    block_t state_reg;
    block_t key_reg;
    block_t state_next;
    block_t key_next;

    always_comb
    begin
        logic [7:0] ss [16];
        logic [7:0] mc [16];
        logic [7:0] rk [16];
        logic [7:0] t  [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                ss[c * 4 + r] = SBOX[get_byte(state_in, ((c + r) % 4) * 4 + r)];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            mc[c * 4]     = gf_double(ss[c * 4]) ^ gf_double(ss[c * 4 + 1]) ^ ss[c * 4 + 1]
                            ^ ss[c * 4 + 2] ^ ss[c * 4 + 3];
            mc[c * 4 + 1] = ss[c * 4] ^ gf_double(ss[c * 4 + 1]) ^ gf_double(ss[c * 4 + 2])
                            ^ ss[c * 4 + 2] ^ ss[c * 4 + 3];
            mc[c * 4 + 2] = ss[c * 4] ^ ss[c * 4 + 1] ^ gf_double(ss[c * 4 + 2])
                            ^ gf_double(ss[c * 4 + 3]) ^ ss[c * 4 + 3];
            mc[c * 4 + 3] = gf_double(ss[c * 4]) ^ ss[c * 4] ^ ss[c * 4 + 1] ^ ss[c * 4 + 2]
                            ^ gf_double(ss[c * 4 + 3]);
        end
        t[0] = SBOX[get_byte(key_in, 13)] ^ Rcon;
        t[1] = SBOX[get_byte(key_in, 14)];
        t[2] = SBOX[get_byte(key_in, 15)];
        t[3] = SBOX[get_byte(key_in, 12)];
        for (int i = 0; i < 4; i++)
        begin
            rk[i] = get_byte(key_in, i) ^ t[i];
        end
        for (int i = 4; i < 16; i++)
        begin
            rk[i] = get_byte(key_in, i) ^ rk[i - 4];
        end
        for (int i = 0; i < 16; i++)
        begin
            key_next[127 - 8 * i -: 8]   = rk[i];
            state_next[127 - 8 * i -: 8] = (LastRound ? ss[i] : mc[i]) ^ rk[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        key_reg   <= key_next;
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;

endmodule

`default_nettype wire

/* rtl/aes128_block_encrypt.sv */
// AES-128 block encryption, one 128-bit request per clock.
// Configuration: cfg_we, cfg_index and cfg_data write key_high (index 0) or
// key_low (index 1); other indexes are ignored. Write the key while idle.
// Requests: plain_high/plain_low are taken at a rising edge where start is
// high and busy is low. busy is always low, so a request may come every cycle.
// Results: cipher_high/cipher_low appear with done high for exactly one cycle,
// after passing one register for the initial key add and one per round in a
// chain of ten round cells, each also expanding its key.
// Throughput is one block per cycle; the receiver cannot stall and none is
// needed, the chain always advances.
// Reset clears the key registers to zero and drops all in-flight requests.
`default_nettype none

module aes128_block_encrypt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] plain_high,
    input  wire logic [63:0] plain_low,
    output logic             done,
    output logic [63:0]      cipher_high,
    output logic [63:0]      cipher_low
);
    import aes_pkg::*;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        valid_reg;
    block_t      state_reg;
    block_t      key_reg;

    logic   valid_c [NumRounds + 1];
    block_t state_c [NumRounds + 1];
    block_t key_c   [NumRounds + 1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CfgKeyHigh)
            begin
                key_high_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CfgKeyLow)
            begin
                key_low_reg <= cfg_data;
            end
            valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= {plain_high, plain_low} ^ {key_high_reg, key_low_reg};
        key_reg   <= {key_high_reg, key_low_reg};
    end

    assign valid_c[0] = valid_reg;
    assign state_c[0] = state_reg;
    assign key_c[0]   = key_reg;

    for (genvar g = 0; g < NumRounds; g++)
    begin : g_round
        aes_round_cell #(
            .Rcon      (RCON[g]),
            .LastRound (g == NumRounds - 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_c[g]),
            .state_in  (state_c[g]),
            .key_in    (key_c[g]),
            .valid_out (valid_c[g + 1]),
            .state_out (state_c[g + 1]),
            .key_out   (key_c[g + 1])
        );
    end

    assign busy        = 1'b0;
    assign done        = valid_c[NumRounds];
    assign cipher_high = state_c[NumRounds][127:64];
    assign cipher_low  = state_c[NumRounds][63:0];

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> valid_reg)
        else $error("accepted request not entered");
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_c[1] |-> ##9 done)
        else $error("request lost in round chain");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_reg, 10))
        else $error("result without request");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import aes_pkg::*;

    localparam int Latency = 11;
    localparam longint CycleLimit = 400000;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } cblock_t;

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    class cipher_board;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        cblock_t     pending[$];
        int          mismatches;

        function cblock_t encrypt(input logic [63:0] phi, input logic [63:0] plo);
            logic [7:0] st[16];
            logic [7:0] rk[16];
            logic [7:0] tmp[16];
            logic [7:0] t[4];
            logic [7:0] a[4];
            logic [7:0] rcon;
            cblock_t    res;
            rcon = 8'h01;
            for (int i = 0; i < 8; i++)
            begin
                st[i]     = phi[63 - 8 * i -: 8] ^ key_hi[63 - 8 * i -: 8];
                st[8 + i] = plo[63 - 8 * i -: 8] ^ key_lo[63 - 8 * i -: 8];
                rk[i]     = key_hi[63 - 8 * i -: 8];
                rk[8 + i] = key_lo[63 - 8 * i -: 8];
            end
            for (int r = 1; r <= 10; r++)
            begin
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++)
                        tmp[c * 4 + w] = SBOX[st[((c + w) % 4) * 4 + w]];
                st = tmp;
                if (r < 10)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int w = 0; w < 4; w++)
                            a[w] = st[c * 4 + w];
                        for (int w = 0; w < 4; w++)
                            st[c * 4 + w] = xtime(a[w]) ^ xtime(a[(w + 1) % 4])
                                ^ a[(w + 1) % 4] ^ a[(w + 2) % 4] ^ a[(w + 3) % 4];
                    end
                end
                t[0] = SBOX[rk[13]] ^ rcon;
                t[1] = SBOX[rk[14]];
                t[2] = SBOX[rk[15]];
                t[3] = SBOX[rk[12]];
                for (int i = 0; i < 4; i++)
                    rk[i] ^= t[i];
                for (int i = 4; i < 16; i++)
                    rk[i] ^= rk[i - 4];
                rcon = xtime(rcon);
                for (int i = 0; i < 16; i++)
                    st[i] ^= rk[i];
            end
            for (int i = 0; i < 8; i++)
            begin
                res.hi[63 - 8 * i -: 8] = st[i];
                res.lo[63 - 8 * i -: 8] = st[8 + i];
            end
            return res;
        endfunction

        function void note_request(input logic [63:0] phi, input logic [63:0] plo);
            pending.push_back(encrypt(phi, plo));
        endfunction

        function void check_result(input logic [63:0] chi, input logic [63:0] clo);
            cblock_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h", chi, clo);
                return;
            end
            want = pending.pop_front();
            if (chi !== want.hi || clo !== want.lo)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("cipher mismatch: expected %h %h, got %h %h",
                             want.hi, want.lo, chi, clo);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = CfgKeyHigh;
    logic [63:0] cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] plain_high = '0;
    logic [63:0] plain_low = '0;
    logic        done;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    longint      cycles = 0;
    bit          idle_ok = 1'b1;
    cipher_board board;

    aes128_block_encrypt dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .plain_high(plain_high),
        .plain_low(plain_low), .done(done), .cipher_high(cipher_high),
        .cipher_low(cipher_low)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && done)
            board.check_result(cipher_high, cipher_low);
        if (cycles > CycleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CfgKeyHigh)
            board.key_hi = val;
        else
            board.key_lo = val;
    endtask

    task automatic send_request(input logic [63:0] phi, input logic [63:0] plo);
        int gap;
        if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        plain_high <= phi;
        plain_low <= plo;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(phi, plo);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] sparse64();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            default: return rand64();
        endcase
    endfunction

    initial
    begin
        board = new();
        board.key_hi = '0;
        board.key_lo = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero key, never written
        send_request('0, '0);
        send_request('1, '1);
        send_request(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();

        write_key(CfgKeyHigh, 64'h0001020304050607);
        write_key(CfgKeyLow, 64'h08090a0b0c0d0e0f);
        send_request(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_request('0, '1);
        send_request('1, '0);
        send_request(64'h8000000000000000, 64'h0000000000000001);
        drain();

        write_key(CfgKeyHigh, '1);
        write_key(CfgKeyLow, '1);
        send_request('0, '0);
        send_request('1, '1);
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            write_key(CfgKeyHigh, sparse64());
            write_key(CfgKeyLow, sparse64());
            if (ph == 11)
                idle_ok = 1'b0;
            for (int n = 0; n < 160; n++)
                send_request(sparse64(), sparse64());
            drain();
        end

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
rtl/aes_pkg.sv
rtl/aes_round_cell.sv
rtl/aes128_block_encrypt.sv
tb/sv/testbench.sv
